FILE: rtl/lcdseq_pkg.sv
package lcdseq_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_STROBE   = 3'd0,
		REG_SETUP    = 3'd1,
		REG_POLL_LIM = 3'd2,
		REG_POWER_UP = 3'd3,
		REG_INIT_GAP = 3'd4
	} reg_idx_t;

	// job codes held in the step counter; 0..3 init nibbles, 4..7 init commands
	localparam logic [3:0] STEP_FIRST_CMD = 4'd4;
	localparam logic [3:0] STEP_LAST_NIB  = 4'd3;
	localparam logic [3:0] JOB_WRITE      = 4'd8;
	localparam logic [3:0] JOB_READ       = 4'd9;

	localparam logic [3:0] NIB_WAKE = 4'h3;
	localparam logic [3:0] NIB_4BIT = 4'h2;
	localparam logic [7:0] INIT_POLLS = 8'hFF;

	localparam logic [7:0]  RST_STROBE   = 8'd60;
	localparam logic [7:0]  RST_SETUP    = 8'd1;
	localparam logic [7:0]  RST_POLL_LIM = 8'd255;
	localparam logic [15:0] RST_POWER_UP = 16'd20000;
	localparam logic [15:0] RST_INIT_GAP = 16'd5000;

	// result item, last field in the lowest bits
	typedef struct packed {
		logic [3:0] pad;
		logic       rejected;
		logic [7:0] read_byte;
		logic       timed_out;
		logic       done_res;
		logic       idle;
		logic       bus_drive;
		logic [3:0] bus_out;
		logic       rw_pin;
		logic       rs_pin;
		logic       en_pin;
	} res_t;

	function automatic logic [7:0] init_cmd(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h28;
			2'd1: c = 8'h0F;
			2'd2: c = 8'h01;
			default: c = 8'h06;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/char_lcd_nibble_bus_sequencer.sv
// Character LCD 4-bit bus sequencer. Each request on the slave stream is a tick of one
// microsecond (op 0) or a start of write, read or init; the block takes one request per
// clock and returns each result next cycle from its output register, so a stream with
// no back-pressure runs at one request per cycle. All timing of the display (power-up
// wait, enable high and setup times, gaps, busy polling) is counted in ticks, never in
// clocks. A start request that arrives while a request is in progress is dropped and
// flagged as rejected. Registers sit on the APB port at byte addresses 0, 4, 8, 12, 16:
// strobe_us, setup_us, poll_limit, power_up_us, init_gap_us; write them only while idle.
module char_lcd_nibble_bus_sequencer #(
	parameter int WAIT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], rs_sel[8], bus_in[12:9], zero pad
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // en_pin, rs_pin, rw_pin, bus_out[4], bus_drive, idle,
	                              // done_res, timed_out, read_byte[8], rejected, zero pad
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_POWER, PH_INIT_HI, PH_INIT_GAP, PH_RD_SET1, PH_RD_HI1,
		PH_RD_SET2, PH_RD_HI2, PH_WR_HI1, PH_WR_LOW, PH_WR_HI2
	} phase_t;

	localparam int DW = (WAIT_BITS > 16) ? WAIT_BITS : 16;
	localparam logic [DW-1:0] WMAX = DW'((64'd1 << WAIT_BITS) - 64'd1);
	localparam logic [WAIT_BITS-1:0] W_ONE = WAIT_BITS'(1);

	function automatic logic [WAIT_BITS-1:0] sat_load(input logic [15:0] dur);
		logic [DW-1:0] ext;
		ext = DW'(dur);
		if (ext > WMAX) begin
			return WMAX[WAIT_BITS-1:0];
		end
		return ext[WAIT_BITS-1:0];
	endfunction

	// configuration
	logic [7:0]  strobe_q, setup_q, poll_lim_q;
	logic [15:0] power_up_q, init_gap_q;
	lcdseq_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = lcdseq_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q   <= lcdseq_pkg::RST_STROBE;
			setup_q    <= lcdseq_pkg::RST_SETUP;
			poll_lim_q <= lcdseq_pkg::RST_POLL_LIM;
			power_up_q <= lcdseq_pkg::RST_POWER_UP;
			init_gap_q <= lcdseq_pkg::RST_INIT_GAP;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				lcdseq_pkg::REG_STROBE:   strobe_q   <= pwdata[7:0];
				lcdseq_pkg::REG_SETUP:    setup_q    <= pwdata[7:0];
				lcdseq_pkg::REG_POLL_LIM: poll_lim_q <= pwdata[7:0];
				lcdseq_pkg::REG_POWER_UP: power_up_q <= pwdata[15:0];
				lcdseq_pkg::REG_INIT_GAP: init_gap_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lcdseq_pkg::REG_STROBE:   prdata = {24'd0, strobe_q};
			lcdseq_pkg::REG_SETUP:    prdata = {24'd0, setup_q};
			lcdseq_pkg::REG_POLL_LIM: prdata = {24'd0, poll_lim_q};
			lcdseq_pkg::REG_POWER_UP: prdata = {16'd0, power_up_q};
			lcdseq_pkg::REG_INIT_GAP: prdata = {16'd0, init_gap_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// sequencer state
	phase_t               phase_q, phase_d;
	logic [WAIT_BITS-1:0] wait_q, wait_d;
	logic [7:0]           byte_q, byte_d;
	logic                 rsl_q, rsl_d;
	logic [7:0]           polls_q, polls_d;
	logic [3:0]           step_q, step_d;
	logic [7:0]           rshift_q, rshift_d;
	logic                 en_q, en_d, rs_q, rs_d, rw_q, rw_d, drv_q, drv_d;
	logic [3:0]           bus_q, bus_d;
	lcdseq_pkg::res_t     res_q, res_d;

	lcdseq_pkg::op_t op;
	logic [7:0] in_byte;
	logic       in_rs;
	logic [3:0] in_bus;
	logic       acc;
	logic [3:0] step_inc;
	logic [7:0] rshift_hi2;
	logic       done, tmo, rej;
	logic [7:0] rbyte;

	assign op       = lcdseq_pkg::op_t'(s_tuser);
	assign in_byte  = s_tdata[7:0];
	assign in_rs    = s_tdata[8];
	assign in_bus   = s_tdata[12:9];
	assign s_tready = !m_tvalid || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign step_inc = step_q + 4'd1;
	assign rshift_hi2 = rshift_q | {4'd0, in_bus};

	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		byte_d   = byte_q;
		rsl_d    = rsl_q;
		polls_d  = polls_q;
		step_d   = step_q;
		rshift_d = rshift_q;
		en_d     = en_q;
		rs_d     = rs_q;
		rw_d     = rw_q;
		drv_d    = drv_q;
		bus_d    = bus_q;
		done     = 1'b0;
		tmo      = 1'b0;
		rej      = 1'b0;
		rbyte    = 8'd0;

		if (op != lcdseq_pkg::OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				case (op)
					lcdseq_pkg::OP_WRITE: begin
						step_d  = lcdseq_pkg::JOB_WRITE;
						byte_d  = in_byte;
						rsl_d   = in_rs;
						polls_d = poll_lim_q;
						{en_d, rs_d, rw_d, drv_d, bus_d} = {1'b0, 1'b0, 1'b1, 1'b0, 4'd0};
						phase_d = PH_RD_SET1;
						wait_d  = sat_load({8'd0, setup_q});
					end
					lcdseq_pkg::OP_READ: begin
						step_d  = lcdseq_pkg::JOB_READ;
						rsl_d   = in_rs;
						polls_d = 8'd0;
						{en_d, rs_d, rw_d, drv_d, bus_d} = {1'b0, in_rs, 1'b1, 1'b0, 4'd0};
						phase_d = PH_RD_SET1;
						wait_d  = sat_load({8'd0, setup_q});
					end
					default: begin
						step_d  = 4'd0;
						{en_d, rs_d, rw_d, drv_d, bus_d} = {1'b0, 1'b0, 1'b0, 1'b1, 4'd0};
						phase_d = PH_POWER;
						wait_d  = sat_load(power_up_q);
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			if (wait_q > W_ONE) begin
				wait_d = wait_q - W_ONE;
			end else begin
				unique case (phase_q)
					PH_POWER: begin
						{en_d, rs_d, rw_d, drv_d, bus_d} =
							{1'b1, 1'b0, 1'b0, 1'b1, lcdseq_pkg::NIB_WAKE};
						phase_d = PH_INIT_HI;
						wait_d  = sat_load({8'd0, strobe_q});
					end
					PH_INIT_HI: begin
						en_d    = 1'b0;
						phase_d = PH_INIT_GAP;
						wait_d  = sat_load(init_gap_q);
					end
					PH_INIT_GAP: begin
						if (step_inc < lcdseq_pkg::STEP_FIRST_CMD) begin
							step_d = step_inc;
							{en_d, rs_d, rw_d, drv_d} = {1'b1, 1'b0, 1'b0, 1'b1};
							bus_d = (step_inc == lcdseq_pkg::STEP_LAST_NIB) ?
								lcdseq_pkg::NIB_4BIT : lcdseq_pkg::NIB_WAKE;
							phase_d = PH_INIT_HI;
							wait_d  = sat_load({8'd0, strobe_q});
						end else begin
							step_d  = lcdseq_pkg::STEP_FIRST_CMD;
							byte_d  = lcdseq_pkg::init_cmd(2'd0);
							rsl_d   = 1'b0;
							polls_d = lcdseq_pkg::INIT_POLLS;
							{en_d, rs_d, rw_d, drv_d, bus_d} = {1'b0, 1'b0, 1'b1, 1'b0, 4'd0};
							phase_d = PH_RD_SET1;
							wait_d  = sat_load({8'd0, setup_q});
						end
					end
					PH_RD_SET1, PH_RD_SET2: begin
						en_d    = 1'b1;
						phase_d = (phase_q == PH_RD_SET1) ? PH_RD_HI1 : PH_RD_HI2;
						wait_d  = sat_load({8'd0, strobe_q});
					end
					PH_RD_HI1: begin
						rshift_d = {in_bus, 4'd0};
						en_d     = 1'b0;
						phase_d  = PH_RD_SET2;
						wait_d   = sat_load({8'd0, setup_q});
					end
					PH_RD_HI2: begin
						rshift_d = rshift_hi2;
						en_d     = 1'b0;
						if (step_q == lcdseq_pkg::JOB_READ) begin
							done    = 1'b1;
							rbyte   = rshift_hi2;
							phase_d = PH_IDLE;
							wait_d  = '0;
						end else if (rshift_hi2[7]) begin
							if (polls_q != 8'd0) begin
								// poll again: status read, rs low
								polls_d = polls_q - 8'd1;
								{rs_d, rw_d, drv_d, bus_d} = {1'b0, 1'b1, 1'b0, 4'd0};
								phase_d = PH_RD_SET1;
								wait_d  = sat_load({8'd0, setup_q});
							end else if (step_q == lcdseq_pkg::JOB_WRITE) begin
								done    = 1'b1;
								tmo     = 1'b1;
								phase_d = PH_IDLE;
								wait_d  = '0;
							end else begin
								// skip the busy init command
								step_d = step_inc;
								if (step_inc >= lcdseq_pkg::JOB_WRITE) begin
									done    = 1'b1;
									phase_d = PH_IDLE;
									wait_d  = '0;
								end else begin
									byte_d  = lcdseq_pkg::init_cmd(step_inc[1:0]);
									rsl_d   = 1'b0;
									polls_d = lcdseq_pkg::INIT_POLLS;
									{rs_d, rw_d, drv_d, bus_d} = {1'b0, 1'b1, 1'b0, 4'd0};
									phase_d = PH_RD_SET1;
									wait_d  = sat_load({8'd0, setup_q});
								end
							end
						end else begin
							{en_d, rs_d, rw_d, drv_d, bus_d} =
								{1'b1, rsl_q, 1'b0, 1'b1, byte_q[7:4]};
							phase_d = PH_WR_HI1;
							wait_d  = sat_load({8'd0, strobe_q});
						end
					end
					PH_WR_HI1: begin
						{en_d, rs_d, rw_d, drv_d, bus_d} =
							{1'b0, rsl_q, 1'b0, 1'b1, byte_q[3:0]};
						phase_d = PH_WR_LOW;
						wait_d  = W_ONE;
					end
					PH_WR_LOW: begin
						en_d    = 1'b1;
						phase_d = PH_WR_HI2;
						wait_d  = sat_load({8'd0, strobe_q});
					end
					PH_WR_HI2: begin
						en_d = 1'b0;
						if (step_q == lcdseq_pkg::JOB_WRITE) begin
							done    = 1'b1;
							phase_d = PH_IDLE;
							wait_d  = '0;
						end else begin
							step_d = step_inc;
							if (step_inc >= lcdseq_pkg::JOB_WRITE) begin
								done    = 1'b1;
								phase_d = PH_IDLE;
								wait_d  = '0;
							end else begin
								byte_d  = lcdseq_pkg::init_cmd(step_inc[1:0]);
								rsl_d   = 1'b0;
								polls_d = lcdseq_pkg::INIT_POLLS;
								{rs_d, rw_d, drv_d, bus_d} = {1'b0, 1'b1, 1'b0, 4'd0};
								phase_d = PH_RD_SET1;
								wait_d  = sat_load({8'd0, setup_q});
							end
						end
					end
					default: begin
						en_d    = 1'b0;
						phase_d = PH_IDLE;
						wait_d  = '0;
					end
				endcase
			end
		end

		res_d.pad       = 4'd0;
		res_d.rejected  = rej;
		res_d.read_byte = rbyte;
		res_d.timed_out = tmo;
		res_d.done_res  = done;
		res_d.idle      = (phase_d == PH_IDLE);
		res_d.bus_drive = drv_d;
		res_d.bus_out   = drv_d ? bus_d : 4'd0;
		res_d.rw_pin    = rw_d;
		res_d.rs_pin    = rs_d;
		res_d.en_pin    = en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			wait_q   <= '0;
			byte_q   <= 8'd0;
			rsl_q    <= 1'b0;
			polls_q  <= 8'd0;
			step_q   <= 4'd0;
			rshift_q <= 8'd0;
			en_q     <= 1'b0;
			rs_q     <= 1'b0;
			rw_q     <= 1'b0;
			drv_q    <= 1'b0;
			bus_q    <= 4'd0;
			res_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (acc) begin
				phase_q  <= phase_d;
				wait_q   <= wait_d;
				byte_q   <= byte_d;
				rsl_q    <= rsl_d;
				polls_q  <= polls_d;
				step_q   <= step_d;
				rshift_q <= rshift_d;
				en_q     <= en_d;
				rs_q     <= rs_d;
				rw_q     <= rw_d;
				drv_q    <= drv_d;
				bus_q    <= bus_d;
				res_q    <= res_d;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign m_tdata = res_q;

	// a completed request always leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done_res |-> res_q.idle)
		else $error("done without idle");

	a_tmo_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.timed_out |-> res_q.done_res && res_q.rw_pin)
		else $error("timeout outside a finished status poll");

	// a dropped start request never advances the sequencer
	a_rej_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res_d.rejected |=> res_q.rejected && !res_q.done_res && !res_q.idle)
		else $error("rejected request changed progress");

	a_rbyte_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.read_byte != 8'd0) |-> res_q.done_res && !res_q.timed_out)
		else $error("read byte without completed read");

endmodule

FILE: tb/sv/char_lcd_nibble_bus_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_bus_sequencer_tb;

	localparam int CYCLE_LIMIT = 3_000_000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_POWER, ST_INIT_HI, ST_INIT_GAP,
		ST_RD_SET1, ST_RD_HI1, ST_RD_SET2, ST_RD_HI2,
		ST_WR_HI1, ST_WR_LOW, ST_WR_HI2
	} seq_state_t;

	class lcd_pin_tracker;
		logic [7:0]  strobe_t, setup_t, poll_lim;
		logic [15:0] power_t, gap_t;

		seq_state_t  st;
		logic [15:0] wait_cnt;
		logic [7:0]  byte_hold, rd_shift;
		logic        rs_hold;
		logic [8:0]  polls;
		logic [3:0]  job;
		logic        en, rs, rw, drive;
		logic [3:0]  bus;

		lcdseq_pkg::res_t pin_states_due[$];
		int   errors;

		function new();
			strobe_t = lcdseq_pkg::RST_STROBE;
			setup_t = lcdseq_pkg::RST_SETUP;
			poll_lim = lcdseq_pkg::RST_POLL_LIM;
			power_t = lcdseq_pkg::RST_POWER_UP;
			gap_t = lcdseq_pkg::RST_INIT_GAP;
			st = ST_IDLE;
			wait_cnt = '0;
			byte_hold = '0;
			rd_shift = '0;
			rs_hold = 1'b0;
			polls = '0;
			job = '0;
			set_pins(1'b0, 1'b0, 1'b0, 1'b0, 4'h0);
			errors = 0;
		endfunction

		function void set_register(lcdseq_pkg::reg_idx_t idx, logic [31:0] v);
			case (idx)
				lcdseq_pkg::REG_STROBE:   strobe_t = v[7:0];
				lcdseq_pkg::REG_SETUP:    setup_t = v[7:0];
				lcdseq_pkg::REG_POLL_LIM: poll_lim = v[7:0];
				lcdseq_pkg::REG_POWER_UP: power_t = v[15:0];
				default:                  gap_t = v[15:0];
			endcase
		endfunction

		function void set_pins(logic en_v, logic rs_v, logic rw_v, logic drv_v,
				logic [3:0] bus_v);
			en = en_v;
			rs = rs_v;
			rw = rw_v;
			drive = drv_v;
			bus = bus_v;
		endfunction

		function void load(seq_state_t s, logic [15:0] dur);
			st = s;
			wait_cnt = dur;
		endfunction

		function void begin_poll(logic rsel, logic [8:0] n);
			polls = n;
			set_pins(1'b0, rsel, 1'b1, 1'b0, 4'h0);
			load(ST_RD_SET1, {8'h00, setup_t});
		endfunction

		function void start_command();
			// init commands in order, indexed from the first command step
			case (job[1:0])
				2'd0:    byte_hold = 8'h28;
				2'd1:    byte_hold = 8'h0F;
				2'd2:    byte_hold = 8'h01;
				default: byte_hold = 8'h06;
			endcase
			rs_hold = 1'b0;
			begin_poll(1'b0, {1'b0, lcdseq_pkg::INIT_POLLS});
		endfunction

		// advance to the next init command; true once the last one is through
		function bit next_command();
			job = job + 4'd1;
			if (job >= lcdseq_pkg::JOB_WRITE) begin
				st = ST_IDLE;
				wait_cnt = '0;
				return 1'b1;
			end
			start_command();
			return 1'b0;
		endfunction

		function lcdseq_pkg::res_t advance(lcdseq_pkg::op_t op, logic [7:0] data, logic rsel,
				logic [3:0] bin);
			lcdseq_pkg::res_t r;
			r = '0;
			if (op != lcdseq_pkg::OP_TICK) begin
				if (st != ST_IDLE) begin
					r.rejected = 1'b1;
				end else if (op == lcdseq_pkg::OP_WRITE) begin
					job = lcdseq_pkg::JOB_WRITE;
					byte_hold = data;
					rs_hold = rsel;
					begin_poll(1'b0, {1'b0, poll_lim});
				end else if (op == lcdseq_pkg::OP_READ) begin
					job = lcdseq_pkg::JOB_READ;
					rs_hold = rsel;
					begin_poll(rsel, 9'd0);
				end else begin
					job = 4'd0;
					set_pins(1'b0, 1'b0, 1'b0, 1'b1, 4'h0);
					load(ST_POWER, power_t);
				end
			end else if (st != ST_IDLE) begin
				if (wait_cnt > 16'd1) begin
					wait_cnt = wait_cnt - 16'd1;
				end else begin
					case (st)
						ST_POWER: begin
							set_pins(1'b1, 1'b0, 1'b0, 1'b1, lcdseq_pkg::NIB_WAKE);
							load(ST_INIT_HI, {8'h00, strobe_t});
						end
						ST_INIT_HI: begin
							en = 1'b0;
							load(ST_INIT_GAP, gap_t);
						end
						ST_INIT_GAP: begin
							job = job + 4'd1;
							if (job < lcdseq_pkg::STEP_FIRST_CMD) begin
								set_pins(1'b1, 1'b0, 1'b0, 1'b1,
									job == lcdseq_pkg::STEP_LAST_NIB ?
									lcdseq_pkg::NIB_4BIT : lcdseq_pkg::NIB_WAKE);
								load(ST_INIT_HI, {8'h00, strobe_t});
							end else begin
								job = lcdseq_pkg::STEP_FIRST_CMD;
								start_command();
							end
						end
						ST_RD_SET1: begin
							en = 1'b1;
							load(ST_RD_HI1, {8'h00, strobe_t});
						end
						ST_RD_HI1: begin
							rd_shift = {bin, 4'h0};
							en = 1'b0;
							load(ST_RD_SET2, {8'h00, setup_t});
						end
						ST_RD_SET2: begin
							en = 1'b1;
							load(ST_RD_HI2, {8'h00, strobe_t});
						end
						ST_RD_HI2: begin
							rd_shift = rd_shift | {4'h0, bin};
							en = 1'b0;
							if (job == lcdseq_pkg::JOB_READ) begin
								r.done_res = 1'b1;
								r.read_byte = rd_shift;
								st = ST_IDLE;
								wait_cnt = '0;
							end else if (rd_shift[7]) begin
								if (polls != 9'd0) begin
									begin_poll(1'b0, polls - 9'd1);
								end else if (job == lcdseq_pkg::JOB_WRITE) begin
									r.done_res = 1'b1;
									r.timed_out = 1'b1;
									st = ST_IDLE;
									wait_cnt = '0;
								end else begin
									// display stuck busy: skip this command
									r.done_res = next_command();
								end
							end else begin
								set_pins(1'b1, rs_hold, 1'b0, 1'b1, byte_hold[7:4]);
								load(ST_WR_HI1, {8'h00, strobe_t});
							end
						end
						ST_WR_HI1: begin
							set_pins(1'b0, rs_hold, 1'b0, 1'b1, byte_hold[3:0]);
							load(ST_WR_LOW, 16'd1);
						end
						ST_WR_LOW: begin
							en = 1'b1;
							load(ST_WR_HI2, {8'h00, strobe_t});
						end
						ST_WR_HI2: begin
							en = 1'b0;
							if (job == lcdseq_pkg::JOB_WRITE) begin
								r.done_res = 1'b1;
								st = ST_IDLE;
								wait_cnt = '0;
							end else begin
								r.done_res = next_command();
							end
						end
						default: begin
							en = 1'b0;
							st = ST_IDLE;
							wait_cnt = '0;
						end
					endcase
				end
			end
			r.en_pin = en;
			r.rs_pin = rs;
			r.rw_pin = rw;
			r.bus_out = drive ? bus : 4'h0;
			r.bus_drive = drive;
			r.idle = (st == ST_IDLE);
			return r;
		endfunction

		function void note_request(lcdseq_pkg::op_t op, logic [7:0] data, logic rsel,
				logic [3:0] bin);
			pin_states_due.push_back(advance(op, data, rsel, bin));
		endfunction

		function bit at_rest();
			return st == ST_IDLE;
		endfunction

		function int outstanding();
			return pin_states_due.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
		endtask

		task compare(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_result(lcdseq_pkg::res_t got);
			lcdseq_pkg::res_t want;
			if (pin_states_due.size() == 0) begin
				report("unexpected result", 32'(got), 32'd0);
				return;
			end
			want = pin_states_due.pop_front();
			compare("en_pin", 32'(got.en_pin), 32'(want.en_pin));
			compare("rs_pin", 32'(got.rs_pin), 32'(want.rs_pin));
			compare("rw_pin", 32'(got.rw_pin), 32'(want.rw_pin));
			compare("bus_out", 32'(got.bus_out), 32'(want.bus_out));
			compare("bus_drive", 32'(got.bus_drive), 32'(want.bus_drive));
			compare("idle", 32'(got.idle), 32'(want.idle));
			compare("done_res", 32'(got.done_res), 32'(want.done_res));
			compare("timed_out", 32'(got.timed_out), 32'(want.timed_out));
			compare("read_byte", 32'(got.read_byte), 32'(want.read_byte));
			compare("rejected", 32'(got.rejected), 32'(want.rejected));
		endtask

		task flush_check();
			if (pin_states_due.size() != 0)
				report("results never returned", 32'(pin_states_due.size()), 32'd0);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // data_byte[7:0], rs_sel[8], bus_in[12:9], zero pad
	logic [1:0]  s_tuser = '0;  // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // en_pin, rs_pin, rw_pin, bus_out[4], bus_drive, idle,
	                            // done_res, timed_out, read_byte[8], rejected, zero pad

	lcd_pin_tracker sb = new();
	bit calm = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	char_lcd_nibble_bus_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: stall in random bursts unless the run is in a calm stretch
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// sample between edges; the handshake completes at the next rising edge
	always @(negedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(lcdseq_pkg::res_t'(m_tdata));
	end

	function automatic logic [3:0] bus_pick(int busy_pct);
		logic [3:0] b;
		b = 4'($urandom);
		b[3] = ($urandom_range(0, 99) < busy_pct);
		return b;
	endfunction

	task automatic send(lcdseq_pkg::op_t op, logic [7:0] data, logic rsel, logic [3:0] bin);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, bin, rsel, data};
		do @(negedge clk); while (!s_tready);
		sb.note_request(op, data, rsel, bin);
		@(posedge clk);
	endtask

	task automatic run_until_rest(int busy_pct);
		while (!sb.at_rest())
			send(lcdseq_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
				bus_pick(busy_pct));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(lcdseq_pkg::reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, v);
	endtask

	task automatic load_settings(logic [7:0] strobe, logic [7:0] setup, logic [7:0] polls,
			logic [15:0] power, logic [15:0] gap);
		run_until_rest(0);
		wait_drained();
		write_reg(lcdseq_pkg::REG_STROBE, {24'h0, strobe});
		write_reg(lcdseq_pkg::REG_SETUP, {24'h0, setup});
		write_reg(lcdseq_pkg::REG_POLL_LIM, {24'h0, polls});
		write_reg(lcdseq_pkg::REG_POWER_UP, {16'h0, power});
		write_reg(lcdseq_pkg::REG_INIT_GAP, {16'h0, gap});
	endtask

	// mostly whole requests with ticks to carry them through, some starts while busy
	task automatic random_traffic(int n, int busy_pct);
		int   k;
		int   pick;
		lcdseq_pkg::op_t  op;
		for (k = 0; k < n; k++) begin
			if (sb.at_rest() && $urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 9);
				op = pick < 5 ? lcdseq_pkg::OP_WRITE :
					(pick < 9 ? lcdseq_pkg::OP_READ : lcdseq_pkg::OP_INIT);
				send(op, 8'($urandom), 1'($urandom_range(0, 1)), bus_pick(busy_pct));
			end else if (!sb.at_rest() && $urandom_range(0, 29) == 0) begin
				send(lcdseq_pkg::op_t'($urandom_range(1, 3)), 8'($urandom),
					1'($urandom_range(0, 1)), bus_pick(busy_pct));
			end else begin
				send(lcdseq_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
					bus_pick(busy_pct));
			end
			if ($urandom_range(0, 149) == 0)
				wait_drained();
		end
	endtask

	task automatic random_settings(bit wide_polls);
		load_settings(8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)),
			wide_polls ? 8'($urandom) : 8'($urandom_range(0, 4)),
			16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle tick, read with a start request while busy
		send(lcdseq_pkg::OP_TICK, 8'h00, 1'b0, 4'h0);
		send(lcdseq_pkg::OP_READ, 8'hFF, 1'b1, 4'hF);
		send(lcdseq_pkg::OP_WRITE, 8'h5A, 1'b0, 4'h0);
		run_until_rest(50);

		// shortest timings, no extra polls
		load_settings(8'd1, 8'd0, 8'd0, 16'd0, 16'd0);
		send(lcdseq_pkg::OP_WRITE, 8'hFF, 1'b1, 4'h0);
		run_until_rest(0);
		send(lcdseq_pkg::OP_WRITE, 8'h00, 1'b0, 4'h0);
		run_until_rest(100);
		send(lcdseq_pkg::OP_READ, 8'h00, 1'b0, 4'h0);
		run_until_rest(50);
		send(lcdseq_pkg::OP_INIT, 8'h00, 1'b0, 4'h0);
		send(lcdseq_pkg::OP_READ, 8'hA5, 1'b1, 4'h5);
		send(lcdseq_pkg::OP_INIT, 8'h3C, 1'b0, 4'hA);
		run_until_rest(30);
		send(lcdseq_pkg::OP_INIT, 8'hFF, 1'b1, 4'hF);
		run_until_rest(0);

		random_settings(1'b0);
		random_traffic(150, 30);
		random_settings(1'b0);
		random_traffic(150, 70);
		random_settings(1'b1);
		random_traffic(150, 60);
		random_settings(1'b0);
		random_traffic(150, 10);
		random_settings(1'b0);
		random_traffic(150, 50);
		random_settings(1'b0);
		calm = 1'b1;
		random_traffic(150, 40);

		wait_drained();
		repeat (10) @(posedge clk);
		sb.flush_check();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
